### rtl/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// Shared constants for the exchange sort block: default capacity and word width.
// ----------------------------------------------------------------------------
package esa_pkg;

   // Default number of elements one set may hold
   localparam int unsigned MAX_ELEMENTS_DEF = 64;

   // Default width of one element
   localparam int unsigned DATA_WIDTH_DEF = 16;

endpackage

### rtl/esa_req_if.sv
// ----------------------------------------------------------------------------
// esa_req_if
// Input channel: one unsorted element per word, with an end-of-set flag.
// ----------------------------------------------------------------------------
interface esa_req_if #(
   parameter int unsigned DATA_WIDTH = esa_pkg::DATA_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value;
   logic                  last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

### rtl/esa_rsp_if.sv
// ----------------------------------------------------------------------------
// esa_rsp_if
// Result channel: one sorted element per word, end-of-set and overflow flags.
// ----------------------------------------------------------------------------
interface esa_rsp_if #(
   parameter int unsigned DATA_WIDTH = esa_pkg::DATA_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] sorted_value;
   logic                  last_out;
   logic                  overflow;

   modport source (output valid, output sorted_value, output last_out,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input last_out,
                   input overflow, output ready);
endinterface

### rtl/esa_ram.sv
// ----------------------------------------------------------------------------
// esa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module esa_ram #(
   parameter int unsigned WIDTH = esa_pkg::DATA_WIDTH_DEF,
   parameter int unsigned DEPTH = esa_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/exchange_sort_ascending_core.sv
// ----------------------------------------------------------------------------
// exchange_sort_ascending_core
// Collects a set of unsigned words, sorts it ascending in a single RAM with
// the all-pairs compare-and-swap scheme, then streams the sorted words out.
// ----------------------------------------------------------------------------
// Load: one input word per cycle; the word flagged last starts the sort.
// Sort: one compare per cycle, bound by the single read and single write
//   port of the element RAM.
// Emit: per result word a RAM read, then the output register; waits on ready.
// Reset clears state, fill count, overflow and rsp valid; RAM stays undefined.
// ----------------------------------------------------------------------------
module exchange_sort_ascending_core #(
   parameter int unsigned MAX_ELEMENTS = esa_pkg::MAX_ELEMENTS_DEF,
   parameter int unsigned DATA_WIDTH   = esa_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   esa_req_if.sink     req_chan,
   esa_rsp_if.source   rsp_chan
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   typedef enum logic [2:0] {
      S_LOAD,
      S_FETCH_I,
      S_HOLD_I,
      S_SCAN,
      S_WB,
      S_EMIT_RD,
      S_EMIT_LAT
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;      // elements held
   logic                  ovf_ff, ovf_in;      // a word of this set was dropped
   logic [AW-1:0]         i_ff, i_in;          // outer index
   logic [CW-1:0]         j_ff, j_in;          // next inner read index
   logic [AW-1:0]         cmp_ff, cmp_in;      // index of the word on rd_data
   logic [DATA_WIDTH-1:0] ai_ff, ai_in;        // live copy of element i
   logic [AW-1:0]         k_ff, k_in;          // emit index
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [DATA_WIDTH-1:0] mem_wd;
   logic [AW-1:0]         mem_ra;
   logic [DATA_WIDTH-1:0] mem_rd;

   // element store
   esa_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   // next-state and RAM control
   // Element i lives in ai_ff for the whole inner pass; its RAM entry is stale
   // until the write-back, and is only read when j equals i, which never swaps.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cmp_in       = cmp_ff;
      ai_in        = ai_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = req_chan.value;
      mem_ra       = '0;

      // output word taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_chan.valid) begin
               if (cnt_ff < MAX_CNT) begin
                  mem_we = 1'b1;
                  mem_wa = cnt_ff[AW-1:0];
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  i_in     = '0;
                  state_in = S_FETCH_I;
               end
            end
         end
         S_FETCH_I: begin
            mem_ra   = i_ff;
            state_in = S_HOLD_I;
         end
         S_HOLD_I: begin
            ai_in    = mem_rd;
            mem_ra   = '0;
            cmp_in   = '0;
            j_in     = CW'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // compare-and-swap against the word read last cycle
            if ((cmp_ff != i_ff) && (ai_ff < mem_rd)) begin
               mem_we = 1'b1;
               mem_wa = cmp_ff;
               mem_wd = ai_ff;
               ai_in  = mem_rd;
            end
            if (j_ff < cnt_ff) begin
               mem_ra = j_ff[AW-1:0];
               cmp_in = j_ff[AW-1:0];
               j_in   = j_ff + CW'(1);
            end else begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            mem_we = 1'b1;
            mem_wa = i_ff;
            mem_wd = ai_ff;
            if ((CW'(i_ff) + CW'(1)) < cnt_ff) begin
               i_in     = i_ff + AW'(1);
               state_in = S_FETCH_I;
            end else begin
               k_in     = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            mem_ra = k_ff;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_EMIT_LAT;
            end
         end
         S_EMIT_LAT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mem_rd;
            rsp_ovf_in   = ovf_ff;
            rsp_last_in  = ((CW'(k_ff) + CW'(1)) == cnt_ff);
            if ((CW'(k_ff) + CW'(1)) == cnt_ff) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      cmp_ff      <= cmp_in;
      ai_ff       <= ai_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // ports
   assign req_chan.ready        = (state_ff == S_LOAD);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_data_ff;
   assign rsp_chan.last_out     = rsp_last_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

`ifndef SYNTHESIS
   // fill count never passes capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("element count beyond capacity");

   // inner read index never runs past the set
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (j_ff <= cnt_ff))
      else $error("inner index beyond set size");

   // a new output word only follows a RAM read in the emit phase
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT_LAT))
      else $error("result word raised outside emit");

   // final word of a set returns the block to loading with an empty store
   a_set_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_LAT && (CW'(k_ff) + CW'(1)) == cnt_ff)
      |=> (state_ff == S_LOAD && cnt_ff == '0 && rsp_last_ff))
      else $error("set did not close after final word");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exchange sort block.
// A short table of directed sets runs first: single words at the extremes or in
// alternating bits, ascending, descending, duplicates and mixed sets. Random sets
// follow: mostly small, a few filling the store exactly and a few running past
// capacity. Typed rows carry their expected word; a software sorter predicts the
// rest. Each word leaving the block is compared field by field with the oldest
// prediction. Both channels stall in random bursts, but not in the run's final stretch.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned MAX_N = esa_pkg::MAX_ELEMENTS_DEF;
   localparam int unsigned DW    = esa_pkg::DATA_WIDTH_DEF;

   localparam int RANDOM_ITEMS  = 500;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int DRAIN_CYCLES  = 50;
   localparam int TABLE_ROWS    = 21;

   // One output word as the block should present it
   typedef struct packed {
      logic [DW-1:0] value;
      logic          last;
      logic          overflow;
   } sorted_word_type;

   // One row of directed stimulus; typed rows carry their own expected word
   typedef struct packed {
      logic [DW-1:0] value;
      logic          last;
      logic          typed;
      logic [DW-1:0] exp_value;
      logic          exp_last;
      logic          exp_overflow;
   } stim_row_type;

   logic clock;
   logic reset;

   esa_req_if #(.DATA_WIDTH(DW)) req_chan ();
   esa_rsp_if #(.DATA_WIDTH(DW)) rsp_chan ();

   exchange_sort_ascending_core #(
      .MAX_ELEMENTS (MAX_N),
      .DATA_WIDTH   (DW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Sorter state mirrored on the bench side
   logic [DW-1:0] held_values [MAX_N];
   int            held_count = 0;
   logic          dropped    = 1'b0;

   sorted_word_type pending_sorted [$];
   int            failures   = 0;
   int            items_sent = 0;
   int            cycles     = 0;
   bit            calm       = 1'b0;
   bit            sender_gaps = 1'b1;

   // Directed sets: single words, pairs both ways, duplicates, mixed extremes
   stim_row_type directed_rows [TABLE_ROWS] = '{
      '{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0},
      '{16'h5555, 1'b1, 1'b1, 16'h5555, 1'b1, 1'b0},
      '{16'hAAAA, 1'b1, 1'b1, 16'hAAAA, 1'b1, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0002, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h1234, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0004, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0001, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0042, 1'b1, 1'b1, 16'h0042, 1'b1, 1'b0}
   };

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Store one word; on the closing word, sort the set and, if asked to, queue its outputs
   function automatic void predict_sorted_set(input logic [DW-1:0] v, input logic l,
                                              input bit queue_words);
      int              i;
      int              j;
      int              k;
      logic [DW-1:0]   t;
      sorted_word_type w;
      if (held_count < MAX_N) begin
         held_values[held_count] = v;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (!l) return;
      // all-pairs exchange: swap whenever element i is below element j
      for (i = 0; i < held_count; i++) begin
         for (j = 0; j < held_count; j++) begin
            if (held_values[i] < held_values[j]) begin
               t              = held_values[i];
               held_values[i] = held_values[j];
               held_values[j] = t;
            end
         end
      end
      if (queue_words) begin
         for (k = 0; k < held_count; k++) begin
            w.value    = held_values[k];
            w.last     = (k == held_count - 1);
            w.overflow = dropped;
            pending_sorted.push_back(w);
         end
      end
      held_count = 0;
      dropped    = 1'b0;
   endfunction

   // Offer one word, wait for acceptance, then maybe leave a gap
   task automatic send_word(input logic [DW-1:0] v, input logic l, input bit typed,
                            input sorted_word_type typed_word);
      req_chan.valid <= 1'b1;
      req_chan.value <= v;
      req_chan.last  <= l;
      do @(posedge clock); while (!req_chan.ready);
      predict_sorted_set(v, l, !typed);
      if (typed) pending_sorted.push_back(typed_word);
      items_sent++;
      @(negedge clock);
      if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Result side back-pressure: stall bursts with quiet stretches between
   initial begin
      int stall_left = 0;
      int quiet_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
               quiet_left = $urandom_range(50, 300);
         end else if (quiet_left > 0 || calm) begin
            rsp_chan.ready <= 1'b1;
            if (quiet_left > 0) quiet_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted output word with the oldest prediction
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_sorted.size() == 0) begin
            $display("%0t: unexpected word: value=%h last=%b overflow=%b", $time,
                     rsp_chan.sorted_value, rsp_chan.last_out, rsp_chan.overflow);
            failures++;
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_chan.sorted_value !== want.value || rsp_chan.last_out !== want.last
                || rsp_chan.overflow !== want.overflow) begin
               $display({"%0t: mismatch: expected value=%h last=%b overflow=%b,",
                         " got value=%h last=%b overflow=%b"},
                        $time, want.value, want.last, want.overflow,
                        rsp_chan.sorted_value, rsp_chan.last_out, rsp_chan.overflow);
               failures++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int              r;
      int              k;
      int              set_no;
      int              set_size;
      int              pattern;
      int              first_random;
      logic [DW-1:0]   base;
      logic [DW-1:0]   step;
      logic [DW-1:0]   v;
      sorted_word_type typed_word;

      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.last  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (r = 0; r < TABLE_ROWS; r++) begin
         typed_word.value    = directed_rows[r].exp_value;
         typed_word.last     = directed_rows[r].exp_last;
         typed_word.overflow = directed_rows[r].exp_overflow;
         send_word(directed_rows[r].value, directed_rows[r].last,
                   directed_rows[r].typed, typed_word);
      end

      // random sets; the first three fill the store exactly and run past it
      first_random = items_sent;
      set_no       = 0;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         case (set_no)
            0: set_size = MAX_N;
            1: set_size = MAX_N + 1;
            2: set_size = MAX_N + 6;
            default: begin
               r = $urandom_range(0, 19);
               if (r == 0)      set_size = $urandom_range(MAX_N - 4, MAX_N);
               else if (r == 1) set_size = $urandom_range(MAX_N + 1, MAX_N + 8);
               else             set_size = $urandom_range(1, 12);
            end
         endcase
         pattern     = (set_no < 3) ? 0 : $urandom_range(0, 4);
         base        = DW'($urandom);
         step        = DW'($urandom_range(1, 300));
         sender_gaps = ($urandom_range(0, 3) != 0);
         calm        = (items_sent - first_random) > RANDOM_ITEMS * 17 / 20;
         for (k = 0; k < set_size; k++) begin
            case (pattern)
               0: v = DW'($urandom);
               1: v = DW'($urandom_range(0, 7));          // heavy duplicates
               2: v = base + DW'(k) * step;               // rising run
               3: v = base - DW'(k) * step;               // falling run
               default: begin                             // extremes mixed in
                  r = $urandom_range(0, 2);
                  if (r == 0)      v = '0;
                  else if (r == 1) v = '1;
                  else             v = DW'($urandom);
               end
            endcase
            send_word(v, k == set_size - 1, 1'b0, '0);
         end
         set_no++;
      end
      req_chan.valid <= 1'b0;

      // drain
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
